>>> hw/rtl/aot_pkg.sv
// Shared constants, types and arithmetic helpers of the adaptive oscillator tracker.
package aot_pkg;

    // Sizing of the oscillator.
    localparam int HARMONICS        = 4;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int LUT_BITS         = $clog2(SINE_TABLE_DEPTH);
    localparam int IDX_W            = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;

    // Fixed-point constants.
    localparam logic [19:0]        FREQ_MIN    = 20'd32768;
    localparam logic [19:0]        FREQ_MAX    = 20'd983040;
    localparam logic [19:0]        FREQ_RESET  = 20'd393216;
    localparam logic signed [31:0] EPS_Q16     = 32'sd655;
    localparam logic signed [63:0] RAD_TO_TURN = 64'sd683565276;
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic [15:0]        QUARTER_TURN = 16'h4000;
    localparam logic signed [65:0] SAT_HI      = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO      = -66'sd2147483648;
    localparam logic signed [31:0] INT_MAX     = 32'sh7FFFFFFF;
    localparam logic signed [31:0] INT_MIN     = 32'sh80000000;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_FREQ = 3'd0;
    localparam logic [2:0] CFG_RATE_FREQ  = 3'd1;
    localparam logic [2:0] CFG_RATE_PHASE = 3'd2;
    localparam logic [2:0] CFG_RATE_AMP   = 3'd3;
    localparam logic [2:0] CFG_STEP_TIME  = 3'd4;
    localparam logic [2:0] CFG_LEAD_TIME  = 3'd5;

    // Configuration reset values.
    localparam logic [20:0] RATE_RESET = 21'd32768;
    localparam logic [16:0] STEP_RESET = 17'd328;
    localparam logic [16:0] LEAD_RESET = 17'd1311;

    // Shift selectors for the product helper.
    localparam logic SH15 = 1'b1;
    localparam logic SH16 = 1'b0;

    // Status of the iterative divider.
    typedef struct packed {
        logic busy;
        logic done;
    } aot_div_stat_t;

    typedef logic signed [15:0] sine_lut_t [SINE_TABLE_DEPTH];

    // Builds the Q1.15 sine table over one turn with a fixed-point Taylor series.
    function automatic sine_lut_t build_sine();
        sine_lut_t   lut;
        logic [15:0] t;
        logic [1:0]  q;
        logic [14:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            t = 16'(k << (16 - LUT_BITS));
            q = t[15:14];
            r = {1'b0, t[13:0]};
            if (q[0])
            begin
                r = 15'h4000 - r;
            end
            x    = (64'(r) * HALF_PI_Q30) >> 14;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            term = ((term * x2) >> 30) / 6;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 20;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 42;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 72;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 110;
            sum  = sum - term;
            v = (sum + 64'd16384) >> 15;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            lut[k] = q[1] ? -$signed(16'(v)) : $signed(16'(v));
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine();

    // Table sine of a turn-fraction phase.
    function automatic logic signed [15:0] sine_of(input logic [15:0] ph);
        return SINE_LUT[ph[15 -: LUT_BITS]];
    endfunction

    // Table cosine, a quarter turn ahead of the sine.
    function automatic logic signed [15:0] cosine_of(input logic [15:0] ph);
        return sine_of(ph + QUARTER_TURN);
    endfunction

    // Saturates a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > SAT_HI)
        begin
            return INT_MAX;
        end
        else if (v < SAT_LO)
        begin
            return INT_MIN;
        end
        return v[31:0];
    endfunction

    // Product shifted back to its format by floor and saturated.
    function automatic logic signed [31:0] mulq(input logic signed [32:0] a,
                                                input logic signed [32:0] b,
                                                input logic               sh15);
        logic signed [65:0] p;
        logic signed [65:0] s;
        p = a * b;
        s = sh15 ? (p >>> 15) : (p >>> 16);
        return sat32(s);
    endfunction

    // Converts a Q16.16 radian step into a phase step modulo one turn.
    function automatic logic [15:0] phase_step(input logic signed [31:0] rad);
        logic signed [63:0] p;
        p = 64'(rad) * RAD_TO_TURN;
        return p[47:32];
    endfunction

endpackage

>>> hw/rtl/aot_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module aot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/aot_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating and saturating.
module aot_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [47:0]    num,
    input  logic signed [31:0]    den,
    output logic signed [31:0]    quo,
    output aot_pkg::aot_div_stat_t stat
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;
    localparam logic [5:0] LAST_STEP = 6'd47;

    logic [1:0]  dstate_reg;
    logic [5:0]  cnt_reg;
    logic [47:0] dvd_reg;
    logic [31:0] dsr_reg;
    logic [31:0] rem_reg;
    logic        neg_reg;
    logic        zden_reg;
    logic        nneg_reg;
    logic        nzero_reg;
    logic [32:0] shifted;
    logic [33:0] diff;
    logic        ge;

    // One restoring step.
    assign shifted = {rem_reg, dvd_reg[47]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign ge      = !diff[33];

    // Control sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg <= D_IDLE;
            cnt_reg    <= '0;
        end
        else
        begin
            unique case (dstate_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        dstate_reg <= D_RUN;
                        cnt_reg    <= '0;
                    end
                end
                D_RUN:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == LAST_STEP)
                    begin
                        dstate_reg <= D_FIN;
                    end
                end
                D_FIN:
                begin
                    dstate_reg <= D_IDLE;
                end
                default:
                begin
                    dstate_reg <= D_IDLE;
                end
            endcase
        end
    end

    // Operand magnitudes and the shifting remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (dstate_reg == D_IDLE && start)
        begin
            dvd_reg   <= num[47] ? (~num + 48'd1) : num;
            dsr_reg   <= den[31] ? (~den + 32'd1) : den;
            rem_reg   <= '0;
            neg_reg   <= num[47] ^ den[31];
            zden_reg  <= (den == '0);
            nneg_reg  <= num[47];
            nzero_reg <= (num == '0);
        end
        else if (dstate_reg == D_RUN)
        begin
            rem_reg <= ge ? diff[31:0] : shifted[31:0];
            dvd_reg <= {dvd_reg[46:0], ge};
        end
    end

    // Sign and saturation of the finished quotient.
    always_comb
    begin
        if (zden_reg)
        begin
            quo = nzero_reg ? '0 : (nneg_reg ? aot_pkg::INT_MIN : aot_pkg::INT_MAX);
        end
        else if (!neg_reg)
        begin
            quo = (dvd_reg > 48'h7FFFFFFF) ? aot_pkg::INT_MAX : $signed(dvd_reg[31:0]);
        end
        else
        begin
            quo = (dvd_reg > 48'h80000000) ? aot_pkg::INT_MIN
                                           : $signed(~dvd_reg[31:0] + 32'd1);
        end
    end

    assign stat.busy = (dstate_reg != D_IDLE);
    assign stat.done = (dstate_reg == D_FIN);

endmodule

>>> hw/rtl/adaptive_oscillator_tracker.sv
// Top level of the adaptive oscillator tracker: sequencer, datapath and state RAM.
//
// One joint-angle sample enters per transaction on the slave stream (s_tdata, Q16.16).
// For each sample the block forms the oscillator estimate, normalizes the error by the
// amplitude sum, updates frequency, phases, amplitudes and bias, and returns one result
// transaction on the master stream with the estimate, the lead-time prediction and the
// new base frequency. Phases and amplitudes live in a small RAM that the sequencer
// reads and writes back one harmonic at a time; the error is divided in a 48-step
// divider. s_tready is high only while no sample is in work. A finished result waits
// in the output register; a stalled receiver blocks the block only when a second
// result is ready before the first is taken.
// Configuration writes take effect at once; they are to be made only while idle by
// the user, as the block itself does not enforce it. Writes to start_frequency are
// ignored. Reset restores the control and configuration registers to their defaults,
// the frequency to 6 rad/s and the phases, amplitudes and bias to zero.
module adaptive_oscillator_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [31:0] estimated_angle, [63:32] predicted_angle,
                                   // [83:64] base_frequency, [87:84] zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [20:0] cfg_data
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_A_RD    = 5'd1;
    localparam logic [4:0] S_A_MUL   = 5'd2;
    localparam logic [4:0] S_A_ACC   = 5'd3;
    localparam logic [4:0] S_ERR     = 5'd4;
    localparam logic [4:0] S_DIVGO   = 5'd5;
    localparam logic [4:0] S_DIV     = 5'd6;
    localparam logic [4:0] S_F1      = 5'd7;
    localparam logic [4:0] S_F2      = 5'd8;
    localparam logic [4:0] S_F3      = 5'd9;
    localparam logic [4:0] S_F4      = 5'd10;
    localparam logic [4:0] S_U_RD    = 5'd11;
    localparam logic [4:0] S_U_COS   = 5'd12;
    localparam logic [4:0] S_U_RAD   = 5'd13;
    localparam logic [4:0] S_U_STEP  = 5'd14;
    localparam logic [4:0] S_U_PH    = 5'd15;
    localparam logic [4:0] S_U_G     = 5'd16;
    localparam logic [4:0] S_U_DAMP  = 5'd17;
    localparam logic [4:0] S_U_WR    = 5'd18;
    localparam logic [4:0] S_BIAS    = 5'd19;
    localparam logic [4:0] S_BIAS2   = 5'd20;
    localparam logic [4:0] S_P_RD    = 5'd21;
    localparam logic [4:0] S_P_AHEAD = 5'd22;
    localparam logic [4:0] S_P_PH    = 5'd23;
    localparam logic [4:0] S_P_MUL   = 5'd24;
    localparam logic [4:0] S_P_ACC   = 5'd25;
    localparam logic [4:0] S_OUT     = 5'd26;

    // Control state.
    logic [4:0]                       state_reg, state_next;
    logic [aot_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [aot_pkg::HARMONICS-1:0]    valid_reg, valid_next;
    logic                             rd_valid_reg, rd_valid_next;
    logic [19:0]                      freq_reg, freq_next;
    logic signed [31:0]               bias_reg, bias_next;
    logic                             m_tvalid_reg, m_tvalid_next;

    // Configuration.
    logic [20:0] rf_reg;
    logic [20:0] rp_reg;
    logic [20:0] ra_reg;
    logic [16:0] st_reg;
    logic [16:0] lt_reg;

    // Datapath registers.
    logic signed [31:0] sample_reg, sample_next;
    logic signed [39:0] est_acc_reg, est_acc_next;
    logic signed [39:0] sum_acc_reg, sum_acc_next;
    logic signed [32:0] prod_reg, prod_next;
    logic signed [15:0] cos0_reg, cos0_next;
    logic signed [31:0] est_reg, est_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [31:0] asum_reg, asum_next;
    logic signed [31:0] enorm_reg, enorm_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] pe_reg, pe_next;
    logic signed [31:0] grow_reg, grow_next;
    logic [23:0]        kf_reg, kf_next;
    logic [15:0]        phn_reg, phn_next;
    logic signed [39:0] pred_acc_reg, pred_acc_next;
    logic signed [31:0] out_est_reg, out_est_next;
    logic signed [31:0] out_pred_reg, out_pred_next;
    logic [19:0]        out_freq_reg, out_freq_next;

    // RAM and divider connections.
    logic        ram_we;
    logic        ram_re;
    logic [47:0] ram_wdata;
    logic [47:0] ram_rdata;
    logic        div_start;
    logic signed [31:0] div_quo;
    aot_pkg::aot_div_stat_t div_stat;

    // Combinational helpers.
    logic               idx_last;
    logic signed [31:0] entry_amp;
    logic [15:0]        entry_ph;
    logic [15:0]        lk_ph;
    logic signed [15:0] sin_lk;
    logic signed [15:0] cos_ent;
    logic signed [47:0] amp_term;
    logic signed [31:0] est_sat;
    logic signed [33:0] fsum;
    logic signed [31:0] amp_new;

    // Phase and amplitude store, {phase, amplitude} per harmonic.
    aot_ram #(
        .WIDTH (48),
        .DEPTH (aot_pkg::HARMONICS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Error normalization.
    aot_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({err_reg, 16'h0000}),
        .den   (asum_reg),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    // Entries never written read as zero.
    assign entry_amp = rd_valid_reg ? $signed(ram_rdata[31:0]) : '0;
    assign entry_ph  = rd_valid_reg ? ram_rdata[47:32] : '0;
    assign idx_last  = (idx_reg == aot_pkg::IDX_W'(aot_pkg::HARMONICS - 1));

    // Shared table lookups and the amplitude-times-sine product.
    assign lk_ph    = (state_reg == S_P_MUL || state_reg == S_U_G) ? phn_reg : entry_ph;
    assign sin_lk   = aot_pkg::sine_of(lk_ph);
    assign cos_ent  = aot_pkg::cosine_of(entry_ph);
    assign amp_term = entry_amp * sin_lk;
    assign est_sat  = aot_pkg::sat32(66'(est_acc_reg));
    assign fsum     = $signed(34'(freq_reg)) + 34'(t_reg);
    assign amp_new  = aot_pkg::sat32(66'(entry_amp) + 66'(t_reg));

    assign ram_wdata = {phn_reg, amp_new};
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {4'h0, out_freq_reg, out_pred_reg, out_est_reg};

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        valid_next    = valid_reg;
        rd_valid_next = rd_valid_reg;
        freq_next     = freq_reg;
        bias_next     = bias_reg;
        m_tvalid_next = m_tvalid_reg;
        sample_next   = sample_reg;
        est_acc_next  = est_acc_reg;
        sum_acc_next  = sum_acc_reg;
        prod_next     = prod_reg;
        cos0_next     = cos0_reg;
        est_next      = est_reg;
        err_next      = err_reg;
        asum_next     = asum_reg;
        enorm_next    = enorm_reg;
        t_next        = t_reg;
        pe_next       = pe_reg;
        grow_next     = grow_reg;
        kf_next       = kf_reg;
        phn_next      = phn_reg;
        pred_acc_next = pred_acc_reg;
        out_est_next  = out_est_reg;
        out_pred_next = out_pred_reg;
        out_freq_next = out_freq_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        div_start     = 1'b0;

        // A taken result frees the output register.
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    sample_next  = $signed(s_tdata);
                    est_acc_next = 40'(bias_reg);
                    sum_acc_next = 40'(aot_pkg::EPS_Q16);
                    idx_next     = '0;
                    state_next   = S_A_RD;
                end
            end
            // Estimate pass over the harmonics.
            S_A_RD:
            begin
                ram_re        = 1'b1;
                rd_valid_next = valid_reg[idx_reg];
                state_next    = S_A_MUL;
            end
            S_A_MUL:
            begin
                prod_next    = amp_term[47:15];
                sum_acc_next = sum_acc_reg + 40'(entry_amp);
                if (idx_reg == '0)
                begin
                    cos0_next = cos_ent;
                end
                state_next = S_A_ACC;
            end
            S_A_ACC:
            begin
                est_acc_next = est_acc_reg + 40'(prod_reg);
                if (idx_last)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_A_RD;
                end
            end
            S_ERR:
            begin
                est_next   = est_sat;
                err_next   = aot_pkg::sat32(66'(sample_reg) - 66'(est_sat));
                asum_next  = aot_pkg::sat32(66'(sum_acc_reg));
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    enorm_next = div_quo;
                    state_next = S_F1;
                end
            end
            // Frequency update and the shared learning terms.
            S_F1:
            begin
                t_next    = aot_pkg::mulq($signed(33'(rf_reg)), 33'(enorm_reg), aot_pkg::SH16);
                pe_next   = aot_pkg::mulq($signed(33'(rp_reg)), 33'(enorm_reg), aot_pkg::SH16);
                grow_next = aot_pkg::mulq($signed(33'(ra_reg)), 33'(err_reg), aot_pkg::SH16);
                state_next = S_F2;
            end
            S_F2:
            begin
                t_next     = aot_pkg::mulq(33'(t_reg), 33'(cos0_reg), aot_pkg::SH15);
                state_next = S_F3;
            end
            S_F3:
            begin
                t_next     = aot_pkg::mulq(33'(t_reg), $signed(33'(st_reg)), aot_pkg::SH16);
                state_next = S_F4;
            end
            S_F4:
            begin
                if (fsum < $signed(34'(aot_pkg::FREQ_MIN)))
                begin
                    freq_next = aot_pkg::FREQ_MIN;
                end
                else if (fsum > $signed(34'(aot_pkg::FREQ_MAX)))
                begin
                    freq_next = aot_pkg::FREQ_MAX;
                end
                else
                begin
                    freq_next = fsum[19:0];
                end
                kf_next    = 24'(freq_next);
                idx_next   = '0;
                state_next = S_U_RD;
            end
            // Phase and amplitude update, read-modify-write per harmonic.
            S_U_RD:
            begin
                ram_re        = 1'b1;
                rd_valid_next = valid_reg[idx_reg];
                state_next    = S_U_COS;
            end
            S_U_COS:
            begin
                t_next     = aot_pkg::mulq(33'(pe_reg), 33'(cos_ent), aot_pkg::SH15);
                state_next = S_U_RAD;
            end
            S_U_RAD:
            begin
                t_next     = aot_pkg::sat32($signed(66'(kf_reg)) + 66'(t_reg));
                state_next = S_U_STEP;
            end
            S_U_STEP:
            begin
                t_next     = aot_pkg::mulq(33'(t_reg), $signed(33'(st_reg)), aot_pkg::SH16);
                state_next = S_U_PH;
            end
            S_U_PH:
            begin
                phn_next   = entry_ph + aot_pkg::phase_step(t_reg);
                state_next = S_U_G;
            end
            S_U_G:
            begin
                t_next     = aot_pkg::mulq(33'(grow_reg), 33'(sin_lk), aot_pkg::SH15);
                state_next = S_U_DAMP;
            end
            S_U_DAMP:
            begin
                t_next     = aot_pkg::mulq(33'(t_reg), $signed(33'(st_reg)), aot_pkg::SH16);
                state_next = S_U_WR;
            end
            S_U_WR:
            begin
                ram_we              = 1'b1;
                valid_next[idx_reg] = 1'b1;
                if (idx_last)
                begin
                    state_next = S_BIAS;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    kf_next    = kf_reg + 24'(freq_reg);
                    state_next = S_U_RD;
                end
            end
            // Bias update.
            S_BIAS:
            begin
                t_next     = aot_pkg::mulq(33'(grow_reg), $signed(33'(st_reg)), aot_pkg::SH16);
                state_next = S_BIAS2;
            end
            S_BIAS2:
            begin
                bias_next     = aot_pkg::sat32(66'(bias_reg) + 66'(t_reg));
                pred_acc_next = 40'(bias_next);
                kf_next       = 24'(freq_reg);
                idx_next      = '0;
                state_next    = S_P_RD;
            end
            // Prediction pass over the updated harmonics.
            S_P_RD:
            begin
                ram_re        = 1'b1;
                rd_valid_next = valid_reg[idx_reg];
                state_next    = S_P_AHEAD;
            end
            S_P_AHEAD:
            begin
                t_next = aot_pkg::mulq($signed(33'(kf_reg)), $signed(33'(lt_reg)),
                                       aot_pkg::SH16);
                state_next = S_P_PH;
            end
            S_P_PH:
            begin
                phn_next   = entry_ph + aot_pkg::phase_step(t_reg);
                state_next = S_P_MUL;
            end
            S_P_MUL:
            begin
                prod_next  = amp_term[47:15];
                state_next = S_P_ACC;
            end
            S_P_ACC:
            begin
                pred_acc_next = pred_acc_reg + 40'(prod_reg);
                if (idx_last)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    kf_next    = kf_reg + 24'(freq_reg);
                    state_next = S_P_RD;
                end
            end
            // Hand the result to the output register once it is free.
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_est_next  = est_reg;
                    out_pred_next = aot_pkg::sat32(66'(pred_acc_reg));
                    out_freq_next = freq_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and oscillator state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            freq_reg     <= aot_pkg::FREQ_RESET;
            bias_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
            freq_reg     <= freq_next;
            bias_reg     <= bias_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Configuration registers; writes to start_frequency are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_reg <= aot_pkg::RATE_RESET;
            rp_reg <= aot_pkg::RATE_RESET;
            ra_reg <= aot_pkg::RATE_RESET;
            st_reg <= aot_pkg::STEP_RESET;
            lt_reg <= aot_pkg::LEAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aot_pkg::CFG_RATE_FREQ:  rf_reg <= cfg_data;
                aot_pkg::CFG_RATE_PHASE: rp_reg <= cfg_data;
                aot_pkg::CFG_RATE_AMP:   ra_reg <= cfg_data;
                aot_pkg::CFG_STEP_TIME:  st_reg <= cfg_data[16:0];
                aot_pkg::CFG_LEAD_TIME:  lt_reg <= cfg_data[16:0];
                default:
                begin
                end
            endcase
        end
    end

    // Datapath payload registers.
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        est_acc_reg  <= est_acc_next;
        sum_acc_reg  <= sum_acc_next;
        prod_reg     <= prod_next;
        cos0_reg     <= cos0_next;
        est_reg      <= est_next;
        err_reg      <= err_next;
        asum_reg     <= asum_next;
        enorm_reg    <= enorm_next;
        t_reg        <= t_next;
        pe_reg       <= pe_next;
        grow_reg     <= grow_next;
        kf_reg       <= kf_next;
        phn_reg      <= phn_next;
        pred_acc_reg <= pred_acc_next;
        out_est_reg  <= out_est_next;
        out_pred_reg <= out_pred_next;
        out_freq_reg <= out_freq_next;
    end

    // The frequency never leaves its clamp range.
    assert property (@(posedge clk) disable iff (!rst_n)
        freq_reg >= aot_pkg::FREQ_MIN && freq_reg <= aot_pkg::FREQ_MAX)
        else $error("base frequency outside clamp range");

    // The harmonic index stays inside the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= aot_pkg::IDX_W'(aot_pkg::HARMONICS - 1))
        else $error("harmonic index beyond store depth");

    // The divider only works while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy || div_stat.done) |-> state_reg == S_DIV)
        else $error("divider active outside its wait state");

    // A finished result is posted and the block returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!m_tvalid_reg || m_tready))
        |=> (m_tvalid_reg && state_reg == S_IDLE))
        else $error("result not posted on a free output register");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the adaptive oscillator tracker.
`timescale 1ns / 1ps

module tb;

    localparam int          HOLD_CYCLES  = 600;
    localparam int          STALL_LIMIT  = 6000;
    localparam int          DRAIN_CYCLES = 130;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 55;
    localparam logic [2:0]  CFG_UNUSED   = 3'd7;
    localparam longint      EPS_Q        = 655;
    localparam longint      TURN_SCALE   = 683565276;

    // One result transaction as the receiver sees it.
    typedef struct packed {
        logic [31:0] est;
        logic [31:0] pred;
        logic [19:0] freq;
    } tracker_out_t;

    // One directed row; fixed rows carry a typed-in result.
    typedef struct packed {
        logic [31:0]  sample;
        logic         fixed;
        tracker_out_t result;
    } sample_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [20:0] cfg_data;

    adaptive_oscillator_tracker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state and a shadow of the configuration.
    longint      sine_tbl [aot_pkg::SINE_TABLE_DEPTH];
    longint      rate_f;
    longint      rate_p;
    longint      rate_a;
    longint      dt;
    longint      lead;
    longint      osc_freq;
    logic [15:0] osc_phase [aot_pkg::HARMONICS];
    longint      osc_amp [aot_pkg::HARMONICS];
    longint      osc_bias;

    tracker_out_t pending_outputs [$];
    int           mismatches;
    int           results_seen;
    int           stall_count;
    bit           quiet;
    bit           hold_req;
    bit           hold_taken;
    logic [15:0]  wave_ph;
    logic [15:0]  wave_inc;
    longint       wave_amp;

    always #5 clk = ~clk;

    // Sine table over one turn, Q1.15, from a fixed-point Taylor series.
    function automatic void fill_sine_table();
        longint unsigned t, q, r, x, x2, term, sum, v;
        for (int k = 0; k < aot_pkg::SINE_TABLE_DEPTH; k++)
        begin
            t = (longint'(k) << 16) / aot_pkg::SINE_TABLE_DEPTH;
            q = (t >> 14) & 3;
            r = t & 16'h3FFF;
            if (q[0])
            begin
                r = 16'h4000 - r;
            end
            x    = (r * 64'd1686629713) >> 14;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 5; n++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            v = (sum + 16384) >> 15;
            if (v > 32767)
            begin
                v = 32767;
            end
            sine_tbl[k] = (q >= 2) ? -longint'(v) : longint'(v);
        end
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b, int sh);
        return clip32((a * b) >>> sh);
    endfunction

    function automatic longint sin_at(logic [15:0] ph);
        return sine_tbl[(longint'(ph) * aot_pkg::SINE_TABLE_DEPTH) >> 16];
    endfunction

    function automatic longint cos_at(logic [15:0] ph);
        return sin_at(ph + 16'h4000);
    endfunction

    function automatic logic [15:0] turn_step(longint rad);
        longint p;
        p = (rad * TURN_SCALE) >>> 32;
        return p[15:0];
    endfunction

    // Advances the oscillator by one sample and returns the result it must emit.
    function automatic tracker_out_t oscillator_step(logic [31:0] raw);
        tracker_out_t o;
        longint sample, est, err, asum, enorm, f, grow, term, rad, pred, ahead;
        sample = longint'($signed(raw));
        est  = osc_bias;
        asum = EPS_Q;
        for (int i = 0; i < aot_pkg::HARMONICS; i++)
        begin
            est  += (osc_amp[i] * sin_at(osc_phase[i])) >>> 15;
            asum += osc_amp[i];
        end
        est  = clip32(est);
        asum = clip32(asum);
        err  = clip32(sample - est);
        // An exact zero divisor saturates by the sign of the error.
        if (asum == 0)
        begin
            enorm = (err > 0) ? 64'sd2147483647 : ((err < 0) ? -64'sd2147483648 : 0);
        end
        else
        begin
            enorm = clip32((err * 65536) / asum);
        end
        f = fx_mul(rate_f, enorm, 16);
        f = fx_mul(f, cos_at(osc_phase[0]), 15);
        f = fx_mul(f, dt, 16);
        f = clip32(osc_freq + f);
        if (f < 32768)
        begin
            f = 32768;
        end
        if (f > 983040)
        begin
            f = 983040;
        end
        osc_freq = f;
        grow = fx_mul(rate_a, err, 16);
        for (int i = 0; i < aot_pkg::HARMONICS; i++)
        begin
            term = fx_mul(fx_mul(rate_p, enorm, 16), cos_at(osc_phase[i]), 15);
            rad  = fx_mul(clip32(longint'(i + 1) * f + term), dt, 16);
            osc_phase[i] = osc_phase[i] + turn_step(rad);
            osc_amp[i] = clip32(osc_amp[i]
                + fx_mul(fx_mul(grow, sin_at(osc_phase[i]), 15), dt, 16));
        end
        osc_bias = clip32(osc_bias + fx_mul(grow, dt, 16));
        pred = osc_bias;
        for (int i = 0; i < aot_pkg::HARMONICS; i++)
        begin
            ahead = fx_mul(clip32(longint'(i + 1) * f), lead, 16);
            pred += (osc_amp[i] * sin_at(osc_phase[i] + turn_step(ahead))) >>> 15;
        end
        pred = clip32(pred);
        o.est  = est[31:0];
        o.pred = pred[31:0];
        o.freq = f[19:0];
        return o;
    endfunction

    // Register write; the shadow copy follows it.
    task automatic write_reg(logic [2:0] idx, logic [20:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            aot_pkg::CFG_RATE_FREQ:  rate_f = longint'(val);
            aot_pkg::CFG_RATE_PHASE: rate_p = longint'(val);
            aot_pkg::CFG_RATE_AMP:   rate_a = longint'(val);
            aot_pkg::CFG_STEP_TIME:  dt     = longint'(val[16:0]);
            aot_pkg::CFG_LEAD_TIME:  lead   = longint'(val[16:0]);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Offers one sample; the expectation is queued when the transaction completes.
    task automatic send_sample(logic [31:0] value, bit fixed, tracker_out_t typed);
        tracker_out_t predicted;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = oscillator_step(value);
        pending_outputs.push_back(fixed ? typed : predicted);
    endtask

    // Mostly sine waves with random amplitude and rate, plus noise and extremes.
    function automatic logic [31:0] next_sample();
        longint v;
        int     pick;
        pick = $urandom_range(0, 9);
        if (pick == 9)
        begin
            wave_amp = $urandom_range(0, 262144);
            wave_inc = 16'($urandom_range(16, 2048));
        end
        if (pick == 7)
        begin
            return $urandom;
        end
        if (pick == 8)
        begin
            return ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
        end
        wave_ph = wave_ph + wave_inc;
        v = ((wave_amp * sin_at(wave_ph)) >>> 15) + $signed($urandom_range(0, 2048)) - 1024;
        return v[31:0];
    endfunction

    // Receiver readiness: random bursts, one long hold-off, steady at the end.
    always
    begin
        if (quiet)
        begin
            m_tready <= 1'b1;
            @(posedge clk);
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
        end
        else
        begin
            m_tready <= ($urandom_range(0, 2) != 0);
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Result checker against the oldest expectation.
    always @(posedge clk)
    begin
        tracker_out_t got;
        tracker_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[83:64]};
            results_seen++;
            if (pending_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result est=%h pred=%h freq=%h",
                             got.est, got.pred, got.freq);
                end
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (got !== want || m_tdata[87:84] !== 4'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: est %h/%h pred %h/%h freq %h/%h (exp/got)",
                                 results_seen, want.est, got.est, want.pred, got.pred,
                                 want.freq, got.freq);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_count <= 0;
        end
        else
        begin
            stall_count <= stall_count + 1;
        end
        if (stall_count > STALL_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Main sequence: directed rows, then configuration phases with random samples.
    initial
    begin
        sample_row_t  rows [14];
        tracker_out_t none;
        logic [20:0]  setting [PHASES][6];
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        results_seen = 0;
        stall_count = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        hold_taken = 1'b0;
        wave_ph = '0;
        wave_inc = 16'd300;
        wave_amp = 65536;
        none = '0;
        fill_sine_table();
        rate_f = 32768;
        rate_p = 32768;
        rate_a = 32768;
        dt = 328;
        lead = 1311;
        osc_freq = 393216;
        osc_bias = 0;
        for (int i = 0; i < aot_pkg::HARMONICS; i++)
        begin
            osc_phase[i] = '0;
            osc_amp[i] = 0;
        end

        // After reset a zero sample leaves everything at rest.
        rows[0]  = {32'h00000000, 1'b1, 32'h0, 32'h0, 20'd393216};
        rows[1]  = {32'h7FFFFFFF, 1'b0, none};
        rows[2]  = {32'h80000000, 1'b0, none};
        rows[3]  = {32'h80000000, 1'b0, none};
        rows[4]  = {32'h7FFFFFFF, 1'b0, none};
        rows[5]  = {32'hFFFFFFFF, 1'b0, none};
        rows[6]  = {32'h00000001, 1'b0, none};
        rows[7]  = {32'h00010000, 1'b0, none};
        rows[8]  = {32'hFFFF0000, 1'b0, none};
        rows[9]  = {32'h00000000, 1'b0, none};
        rows[10] = {32'h55555555, 1'b0, none};
        rows[11] = {32'hAAAAAAAA, 1'b0, none};
        rows[12] = {32'h00030000, 1'b0, none};
        rows[13] = {32'hFFFD0000, 1'b0, none};

        // start_frequency, rates, step_time, lead_time per phase.
        setting[0] = '{21'd393216, 21'd32768, 21'd32768, 21'd32768, 21'd328, 21'd1311};
        setting[1] = '{21'd32768, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0};
        setting[2] = '{21'd983040, 21'd1048576, 21'd1048576, 21'd1048576, 21'd65536, 21'd65536};
        setting[3] = '{21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFF, 21'h1FFFF};
        setting[4] = '{21'd500000, 21'd65536, 21'd16384, 21'd8192, 21'd1, 21'd0};
        setting[5] = '{21'd0, 21'd200000, 21'd100000, 21'd50000, 21'd655, 21'd6554};
        setting[6] = '{21'd700000, 21'd4096, 21'd262144, 21'd131072, 21'd3277, 21'd3277};
        setting[7] = '{21'd393216, 21'd32768, 21'd32768, 21'd32768, 21'd328, 21'd1311};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
        begin
            send_sample(rows[r].sample, rows[r].fixed, rows[r].result);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            // The sender pauses until every expected result is back.
            s_tvalid <= 1'b0;
            @(posedge clk);
            wait_drained();
            if (p == 4)
            begin
                for (int j = 0; j < 6; j++)
                begin
                    setting[p][j] = (j == 0) ? 21'($urandom_range(32768, 983040))
                                  : (j < 4)  ? 21'($urandom_range(0, 1048576))
                                  : 21'($urandom_range(1, 65536));
                end
            end
            write_reg(aot_pkg::CFG_START_FREQ, setting[p][0]);
            write_reg(aot_pkg::CFG_RATE_FREQ,  setting[p][1]);
            write_reg(aot_pkg::CFG_RATE_PHASE, setting[p][2]);
            write_reg(aot_pkg::CFG_RATE_AMP,   setting[p][3]);
            write_reg(aot_pkg::CFG_STEP_TIME,  setting[p][4]);
            write_reg(aot_pkg::CFG_LEAD_TIME,  setting[p][5]);
            if (p == 1)
            begin
                write_reg(CFG_UNUSED, 21'h1FFFFF);
            end
            cfg_we <= 1'b0;
            hold_req = (p == 2);
            quiet    = (p == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_sample(next_sample(), 1'b0, none);
            end
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        wait_drained();
        $display("Covered %0d results over %0d register settings, with field extremes,",
                 results_seen, PHASES);
        $display("saturating quotients, zero and full step times and a long receiver stall.");
        if (mismatches == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/aot_pkg.sv
hw/rtl/aot_ram.sv
hw/rtl/aot_div.sv
hw/rtl/adaptive_oscillator_tracker.sv
verif/tb.sv
